### design/gap_pkg.sv
// Shared types and constants of the grid path search block.
`default_nettype none
package gap_pkg;

    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;
    localparam int NODE_AW = ROW_W + COL_W;
    localparam int LINK_W = NODE_AW + 1;
    localparam int COST_W = 40;
    localparam int CS_W   = 16;
    localparam int WGT_W  = 8;

    localparam logic [1:0] ST_UNSEEN = 2'd0;
    localparam logic [1:0] ST_OPEN   = 2'd1;
    localparam logic [1:0] ST_CLOSED = 2'd2;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_RUN  = 1'b1;

    localparam logic [2:0] REG_ROWS     = 3'd0;
    localparam logic [2:0] REG_COLS     = 3'd1;
    localparam logic [2:0] REG_CELLSIZE = 3'd2;
    localparam logic [2:0] REG_DIAG     = 3'd3;
    localparam logic [2:0] REG_OBST     = 3'd4;

    // sqrt(2) in Q.32 is 2^32 plus this remainder.
    localparam logic [30:0] SQRT2_LO = 31'd1779033704;

    localparam logic [LINK_W-1:0] LINK_NIL = {1'b1, {NODE_AW{1'b0}}};

    typedef struct packed {
        logic [1:0]        st;
        logic [COST_W-1:0] g;
        logic [COST_W-1:0] h;
        logic [LINK_W-1:0] nxt;
    } node_t;

endpackage
`default_nettype wire

### design/grid_astar_path_search_top.sv
// Top level of the grid A* path search: memories, sequencer and ports.
`default_nettype none
// A load request (action 0) writes one cell weight, if the index lies within
// the cells in use, and busy stays low, so loads may follow every cycle. A run
// request (action 1) first clears the node status memory, one entry a cycle,
// then expands nodes until the goal is closed or the open list is empty.
// Each expansion visits the neighbors in turn and, to insert a new node,
// walks the open-list entries ahead of it, because the sorted open list
// is a linked list in the one-read, one-write node memory. The result
// appears on found and path_cost for exactly one cycle with done high; the
// receiver cannot stall it. Endpoints outside the rows and columns in use
// give found low and a cost of zero at once. Configuration writes are
// always ready and must only be issued while busy is low.
module grid_astar_path_search_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         action,
    input  wire logic [11:0]                  cell_index,
    input  wire logic [7:0]                   cell_weight_in,
    input  wire logic [5:0]                   start_row,
    input  wire logic [5:0]                   start_col,
    input  wire logic [5:0]                   goal_row,
    input  wire logic [5:0]                   goal_col,
    output logic                              done,
    output logic                              found,
    output logic [39:0]                       path_cost,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [2:0]                   cfg_index,
    input  wire logic [15:0]                  cfg_data
);
    import gap_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CLEAR = 5'd1;
    localparam logic [4:0] S_SH    = 5'd2;
    localparam logic [4:0] S_POP   = 5'd3;
    localparam logic [4:0] S_POPW  = 5'd4;
    localparam logic [4:0] S_NB    = 5'd5;
    localparam logic [4:0] S_NBW   = 5'd6;
    localparam logic [4:0] S_ST2   = 5'd7;
    localparam logic [4:0] S_ST3   = 5'd8;
    localparam logic [4:0] S_UPD   = 5'd9;
    localparam logic [4:0] S_NH    = 5'd10;
    localparam logic [4:0] S_WALK  = 5'd11;
    localparam logic [4:0] S_WALKW = 5'd12;
    localparam logic [4:0] S_WALKF = 5'd13;
    localparam logic [4:0] S_LINK  = 5'd14;
    localparam logic [4:0] S_LINKP = 5'd15;

    // Configuration registers.
    logic [6:0]  rows_reg, cols_reg;
    logic [15:0] cs_reg;
    logic        diag_reg;
    logic [8:0]  obs_reg;
    logic [6:0]  rows_eff, cols_eff;
    logic [13:0] cells;

    logic [4:0]  state_reg, state_next;
    logic [LINK_W-1:0] head_reg;
    logic        done_reg, found_reg;
    logic [COST_W-1:0] cost_reg;

    // Search payload.
    logic [5:0]  sr_reg, sc_reg, gr_reg, gc_reg;
    logic [NODE_AW-1:0] cnt_reg, cur_reg, nid_reg;
    logic [COST_W-1:0]  cur_g_reg, gnew_reg, hn_reg;
    logic [1:0]  ki_reg, kj_reg;
    logic        ndiag_reg;
    node_t       nb_reg, wd_reg, prev_ent_reg;
    logic [23:0] prod_reg;
    logic [54:0] p2_reg;
    logic [40:0] fnew_reg, fcur_reg;
    logic [LINK_W-1:0] wcur_reg, prev_reg;

    // Memories.
    logic [WGT_W-1:0] wmem [0:(1<<NODE_AW)-1];
    node_t            nmem [0:(1<<NODE_AW)-1];
    logic [WGT_W-1:0] wrd_reg;
    node_t            nrd_reg;
    logic             wwe, nwe;
    logic [NODE_AW-1:0] wwa, wra, nwa, nra;
    node_t            nwd;

    // Neighbor scan.
    logic [7:0]  rt, ct, nr8, nc8;
    logic        nb_ok, nb_diag, nb_center, adv_last;
    logic [12:0] nrow_base;
    logic [NODE_AW-1:0] nb_waddr;
    logic [1:0]  ki_n, kj_n;

    // Step cost.
    logic [56:0] full;
    logic [24:0] step;
    logic [40:0] gsum;

    // Heuristic unit.
    logic        hgo, hv;
    logic [5:0]  hrow, hcol;
    logic [COST_W-1:0] hval;

    logic        load_ok, ends_ok;

    gap_heur u_heur (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (hgo),
        .row    (hrow),
        .col    (hcol),
        .goal_r (gr_reg),
        .goal_c (gc_reg),
        .cs     (cs_reg),
        .diag   (diag_reg),
        .hv     (hv),
        .h      (hval)
    );

    always_comb
    begin
        rows_eff = (rows_reg == 7'd0) ? 7'd1 : ((rows_reg > 7'd64) ? 7'd64 : rows_reg);
        cols_eff = (cols_reg == 7'd0) ? 7'd1 : ((cols_reg > 7'd64) ? 7'd64 : cols_reg);
        cells    = rows_eff * cols_eff;
        load_ok  = {2'b0, cell_index} < cells;
        ends_ok  = ({1'b0, start_row} < rows_eff) && ({1'b0, start_col} < cols_eff)
                   && ({1'b0, goal_row} < rows_eff) && ({1'b0, goal_col} < cols_eff);

        // Node ids use a fixed stride of 64 columns; the weight store uses
        // the loaded row-major layout with the columns in use.
        rt        = {2'b0, cur_reg[11:6]} + {6'b0, ki_reg};
        ct        = {2'b0, cur_reg[5:0]} + {6'b0, kj_reg};
        nr8       = rt - 8'd1;
        nc8       = ct - 8'd1;
        nb_center = (ki_reg == 2'd1) && (kj_reg == 2'd1);
        nb_diag   = (ki_reg != 2'd1) && (kj_reg != 2'd1);
        nb_ok     = (rt != 8'd0) && (ct != 8'd0) && (nr8 < {1'b0, rows_eff})
                    && (nc8 < {1'b0, cols_eff}) && !nb_center && !(nb_diag && !diag_reg);
        nrow_base = nr8[5:0] * cols_eff;
        nb_waddr  = NODE_AW'(nrow_base + {7'b0, nc8[5:0]});
        adv_last  = (ki_reg == 2'd2) && (kj_reg == 2'd2);
        kj_n      = (kj_reg == 2'd2) ? 2'd0 : kj_reg + 2'd1;
        ki_n      = (kj_reg == 2'd2) ? ki_reg + 2'd1 : ki_reg;

        // Diagonal step is sqrt2 * cs * w rounded down to a multiple of 256.
        full = {1'b0, prod_reg, 32'b0} + {2'b0, p2_reg};
        step = ndiag_reg ? {full[56:40], 8'b0} : {1'b0, prod_reg};
        gsum = {1'b0, cur_g_reg} + {16'b0, step};
    end

    // Sequencer and memory control.
    always_comb
    begin
        state_next = state_reg;
        wwe  = 1'b0;
        wwa  = cell_index;
        wra  = nb_waddr;
        nwe  = 1'b0;
        nwa  = cnt_reg;
        nra  = head_reg[NODE_AW-1:0];
        nwd  = '0;
        hgo  = 1'b0;
        hrow = sr_reg;
        hcol = sc_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && action == ACT_LOAD)
                    wwe = load_ok;
                else if (start && ends_ok)
                    state_next = S_CLEAR;
            end
            S_CLEAR:
            begin
                nwe = 1'b1;
                nwd.st = ST_UNSEEN;
                if (cnt_reg == {NODE_AW{1'b1}})
                begin
                    hgo = 1'b1;
                    state_next = S_SH;
                end
            end
            S_SH:
            begin
                if (hv)
                begin
                    nwe = 1'b1;
                    nwa = {sr_reg, sc_reg};
                    nwd.st  = ST_OPEN;
                    nwd.h   = hval;
                    nwd.nxt = LINK_NIL;
                    state_next = S_POP;
                end
            end
            S_POP:
                state_next = head_reg[NODE_AW] ? S_IDLE : S_POPW;
            S_POPW:
            begin
                nwe = 1'b1;
                nwa = cur_reg;
                nwd = nrd_reg;
                nwd.st = ST_CLOSED;
                state_next = (cur_reg == {gr_reg, gc_reg}) ? S_IDLE : S_NB;
            end
            S_NB:
            begin
                nra = {nr8[5:0], nc8[5:0]};
                if (nb_ok)
                    state_next = S_NBW;
                else if (adv_last)
                    state_next = S_POP;
            end
            S_NBW:
            begin
                if ({1'b0, wrd_reg} >= obs_reg)
                    state_next = adv_last ? S_POP : S_NB;
                else
                    state_next = S_ST2;
            end
            S_ST2:
                state_next = S_ST3;
            S_ST3:
                state_next = S_UPD;
            S_UPD:
            begin
                nwa = nid_reg;
                if (nb_reg.st != ST_UNSEEN)
                begin
                    if (gnew_reg < nb_reg.g)
                    begin
                        nwe = 1'b1;
                        nwd = nb_reg;
                        nwd.g = gnew_reg;
                    end
                    state_next = adv_last ? S_POP : S_NB;
                end
                else
                begin
                    hgo  = 1'b1;
                    hrow = nid_reg[11:6];
                    hcol = nid_reg[5:0];
                    state_next = S_NH;
                end
            end
            S_NH:
                if (hv)
                    state_next = S_WALK;
            S_WALK:
            begin
                nra = wcur_reg[NODE_AW-1:0];
                state_next = wcur_reg[NODE_AW] ? S_LINK : S_WALKW;
            end
            S_WALKW:
                state_next = S_WALKF;
            S_WALKF:
                state_next = (fnew_reg > fcur_reg) ? S_WALK : S_LINK;
            S_LINK:
            begin
                nwe = 1'b1;
                nwa = nid_reg;
                nwd.st  = ST_OPEN;
                nwd.g   = gnew_reg;
                nwd.h   = hn_reg;
                nwd.nxt = wcur_reg;
                if (!prev_reg[NODE_AW])
                    state_next = S_LINKP;
                else
                    state_next = adv_last ? S_POP : S_NB;
            end
            S_LINKP:
            begin
                nwe = 1'b1;
                nwa = prev_reg[NODE_AW-1:0];
                nwd = prev_ent_reg;
                nwd.nxt = {1'b0, nid_reg};
                state_next = adv_last ? S_POP : S_NB;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wwe)
            wmem[wwa] <= cell_weight_in;
        wrd_reg <= wmem[wra];
        if (nwe)
            nmem[nwa] <= nwd;
        nrd_reg <= nmem[nra];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= LINK_NIL;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            cost_reg  <= '0;
            rows_reg  <= 7'd64;
            cols_reg  <= 7'd64;
            cs_reg    <= 16'd256;
            diag_reg  <= 1'b1;
            obs_reg   <= 9'd255;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ROWS:     rows_reg <= cfg_data[6:0];
                    REG_COLS:     cols_reg <= cfg_data[6:0];
                    REG_CELLSIZE: cs_reg   <= cfg_data;
                    REG_DIAG:     diag_reg <= cfg_data[0];
                    REG_OBST:     obs_reg  <= cfg_data[8:0];
                    default:      ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start && action == ACT_RUN && !ends_ok)
                    begin
                        done_reg  <= 1'b1;
                        found_reg <= 1'b0;
                        cost_reg  <= '0;
                    end
                end
                S_SH:
                    if (hv)
                        head_reg <= {1'b0, sr_reg, sc_reg};
                S_POP:
                begin
                    if (head_reg[NODE_AW])
                    begin
                        done_reg  <= 1'b1;
                        found_reg <= 1'b0;
                        cost_reg  <= '0;
                    end
                end
                S_POPW:
                begin
                    head_reg <= nrd_reg.nxt;
                    if (cur_reg == {gr_reg, gc_reg})
                    begin
                        done_reg  <= 1'b1;
                        found_reg <= 1'b1;
                        cost_reg  <= nrd_reg.g;
                    end
                end
                S_LINK:
                    if (prev_reg[NODE_AW])
                        head_reg <= {1'b0, nid_reg};
                default: ;
            endcase
        end
    end

    // Search payload registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                sr_reg  <= start_row;
                sc_reg  <= start_col;
                gr_reg  <= goal_row;
                gc_reg  <= goal_col;
                cnt_reg <= '0;
            end
            S_CLEAR:
                cnt_reg <= cnt_reg + 1'b1;
            S_POP:
                cur_reg <= head_reg[NODE_AW-1:0];
            S_POPW:
            begin
                cur_g_reg <= nrd_reg.g;
                ki_reg    <= 2'd0;
                kj_reg    <= 2'd0;
            end
            S_NB:
            begin
                nid_reg   <= {nr8[5:0], nc8[5:0]};
                ndiag_reg <= nb_diag;
                if (!nb_ok)
                begin
                    ki_reg <= ki_n;
                    kj_reg <= kj_n;
                end
            end
            S_NBW:
            begin
                nb_reg   <= nrd_reg;
                prod_reg <= cs_reg * wrd_reg;
                if ({1'b0, wrd_reg} >= obs_reg)
                begin
                    ki_reg <= ki_n;
                    kj_reg <= kj_n;
                end
            end
            S_ST2:
                p2_reg <= prod_reg * SQRT2_LO;
            S_ST3:
                gnew_reg <= gsum[40] ? {COST_W{1'b1}} : gsum[COST_W-1:0];
            S_UPD:
            begin
                if (nb_reg.st != ST_UNSEEN)
                begin
                    ki_reg <= ki_n;
                    kj_reg <= kj_n;
                end
            end
            S_NH:
            begin
                hn_reg   <= hval;
                fnew_reg <= {1'b0, gnew_reg} + {1'b0, hval};
                prev_reg <= LINK_NIL;
                wcur_reg <= head_reg;
            end
            S_WALKW:
            begin
                wd_reg   <= nrd_reg;
                fcur_reg <= {1'b0, nrd_reg.g} + {1'b0, nrd_reg.h};
            end
            S_WALKF:
            begin
                if (fnew_reg > fcur_reg)
                begin
                    prev_reg     <= wcur_reg;
                    prev_ent_reg <= wd_reg;
                    wcur_reg     <= wd_reg.nxt;
                end
            end
            S_LINK:
            begin
                if (prev_reg[NODE_AW])
                begin
                    ki_reg <= ki_n;
                    kj_reg <= kj_n;
                end
            end
            S_LINKP:
            begin
                ki_reg <= ki_n;
                kj_reg <= kj_n;
            end
            default: ;
        endcase
    end

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign found     = found_reg;
    assign path_cost = cost_reg;
endmodule
`default_nettype wire

### design/gap_heur.sv
// Three-stage pipelined Manhattan or octile distance heuristic.
`default_nettype none
module gap_heur (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        go,
    input  wire logic [gap_pkg::ROW_W-1:0]   row,
    input  wire logic [gap_pkg::COL_W-1:0]   col,
    input  wire logic [gap_pkg::ROW_W-1:0]   goal_r,
    input  wire logic [gap_pkg::COL_W-1:0]   goal_c,
    input  wire logic [gap_pkg::CS_W-1:0]    cs,
    input  wire logic                        diag,
    output logic                             hv,
    output logic [gap_pkg::COST_W-1:0]       h
);
    import gap_pkg::*;

    logic [5:0]  dr, dc, mn, mx;
    logic [2:0]  v_reg;
    logic [21:0] m1_reg, m2_reg, m1b_reg, m2b_reg;
    logic [22:0] man_reg, manb_reg;
    logic        d_reg, db_reg;
    logic [52:0] p_reg;
    logic [54:0] t;
    logic [COST_W-1:0] h_reg;

    always_comb
    begin
        dr = (row > goal_r) ? row - goal_r : goal_r - row;
        dc = (col > goal_c) ? col - goal_c : goal_c - col;
        mn = (dr < dc) ? dr : dc;
        mx = (dr < dc) ? dc : dr;
        t  = {1'b0, m1b_reg, 32'b0} + {2'b0, p_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[1:0], go};
    end

    always_ff @(posedge clk)
    begin
        m1_reg   <= cs * mn;
        m2_reg   <= cs * (mx - mn);
        man_reg  <= cs * ({1'b0, dr} + {1'b0, dc});
        d_reg    <= diag;
        p_reg    <= m1_reg * SQRT2_LO;
        m1b_reg  <= m1_reg;
        m2b_reg  <= m2_reg;
        manb_reg <= man_reg;
        db_reg   <= d_reg;
        if (db_reg)
            h_reg <= COST_W'({2'b0, m2b_reg} + t[54:32]);
        else
            h_reg <= COST_W'(manb_reg);
    end

    assign hv = v_reg[2];
    assign h  = h_reg;
endmodule
`default_nettype wire

### dv/grid_astar_path_search_top_tb.sv
// Testbench for the grid A* path search block, with a built-in path cost predictor.
`timescale 1ns / 100ps
module grid_astar_path_search_top_tb;
    import gap_pkg::*;

    localparam int          NCELLS    = 4096;
    localparam int          NIL       = 4096;
    localparam longint      RUN_LIMIT = 20_000_000;
    localparam longint unsigned ROOT2_Q32 = 64'd6074001000;
    localparam longint unsigned G_SAT     = (64'd1 << 40) - 64'd1;

    // One search outcome as the block reports it.
    typedef struct {
        bit        found;
        bit [39:0] cost;
    } outcome_t;

    // The scoreboard predicts each search from its own copy of the grid and
    // registers, and compares the block's results against that prediction in order.
    class path_scoreboard;
        int unsigned     rows_reg, cols_reg, cell_cost, diag_on, block_at;
        bit [7:0]        grid_wt[NCELLS];
        bit [1:0]        status[NCELLS];
        longint unsigned g_cost[NCELLS];
        longint unsigned h_cost[NCELLS];
        int              next_open[NCELLS];
        int              open_first;
        outcome_t        pending[$];
        int              mismatches;

        function new();
            rows_reg  = 64;
            cols_reg  = 64;
            cell_cost = 256;
            diag_on   = 1;
            block_at  = 255;
            mismatches = 0;
        endfunction

        function void set_reg(logic [2:0] idx, int unsigned v);
            case (idx)
                REG_ROWS:     rows_reg  = v & 32'h7f;
                REG_COLS:     cols_reg  = v & 32'h7f;
                REG_CELLSIZE: cell_cost = v & 32'hffff;
                REG_DIAG:     diag_on   = v & 32'h1;
                REG_OBST:     block_at  = v & 32'h1ff;
                default: ;
            endcase
        endfunction

        function int unsigned used_rows();
            if (rows_reg == 0) return 1;
            return (rows_reg > 64) ? 64 : rows_reg;
        endfunction

        function int unsigned used_cols();
            if (cols_reg == 0) return 1;
            return (cols_reg > 64) ? 64 : cols_reg;
        endfunction

        // Manhattan distance, or octile distance when diagonals are enabled.
        function longint unsigned estimate(int r, int c, int gr, int gc);
            longint unsigned dr, dc, lo, hi, cs;
            dr = (r > gr) ? r - gr : gr - r;
            dc = (c > gc) ? c - gc : gc - c;
            cs = cell_cost;
            if (diag_on == 0) return cs * (dr + dc);
            lo = (dr < dc) ? dr : dc;
            hi = (dr < dc) ? dc : dr;
            return cs * (hi - lo) + ((cs * lo * ROOT2_Q32) >> 32);
        endfunction

        // Sorted insert; a new node goes ahead of every entry with equal f.
        function void open_insert(int id);
            longint unsigned f;
            int prev, cur;
            f = g_cost[id] + h_cost[id];
            prev = NIL;
            cur = open_first;
            while (cur < NIL && f > g_cost[cur] + h_cost[cur]) begin
                prev = cur;
                cur = next_open[cur];
            end
            next_open[id] = cur;
            if (prev < NIL) next_open[prev] = id;
            else open_first = id;
        endfunction

        function outcome_t search(int sr, int sc, int gr, int gc);
            outcome_t res;
            int rows, cols, src, dst, cur, r, c, nr, nc, nid;
            longint unsigned step, g;
            res.found = 1'b0;
            res.cost  = '0;
            rows = used_rows();
            cols = used_cols();
            if (sr >= rows || sc >= cols || gr >= rows || gc >= cols) return res;
            foreach (status[i]) status[i] = ST_UNSEEN;
            src = sr * cols + sc;
            dst = gr * cols + gc;
            g_cost[src] = 0;
            h_cost[src] = estimate(sr, sc, gr, gc);
            status[src] = ST_OPEN;
            next_open[src] = NIL;
            open_first = src;
            while (open_first < NIL) begin
                cur = open_first;
                r = cur / cols;
                c = cur % cols;
                open_first = next_open[cur];
                status[cur] = ST_CLOSED;
                if (cur == dst) begin
                    res.found = 1'b1;
                    res.cost  = g_cost[cur][39:0];
                    return res;
                end
                for (int di = -1; di <= 1; di++) begin
                    for (int dj = -1; dj <= 1; dj++) begin
                        nr = r + di;
                        nc = c + dj;
                        if (di == 0 && dj == 0) continue;
                        if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
                        nid = nr * cols + nc;
                        if (grid_wt[nid] >= block_at) continue;
                        if (di != 0 && dj != 0) begin
                            if (diag_on == 0) continue;
                            step = (((longint'(cell_cost) * grid_wt[nid]) * ROOT2_Q32)
                                    >> 40) << 8;
                        end else begin
                            step = longint'(cell_cost) * grid_wt[nid];
                        end
                        g = g_cost[cur] + step;
                        if (g > G_SAT) g = G_SAT;
                        if (status[nid] != ST_UNSEEN) begin
                            if (g < g_cost[nid]) g_cost[nid] = g;
                        end else begin
                            g_cost[nid] = g;
                            h_cost[nid] = estimate(nr, nc, gr, gc);
                            status[nid] = ST_OPEN;
                            open_insert(nid);
                        end
                    end
                end
            end
            return res;
        endfunction

        // Called for every accepted request.
        function void note_request(bit act, int idx, int wt, int sr, int sc, int gr, int gc);
            if (act == ACT_LOAD) begin
                if (idx < used_rows() * used_cols()) grid_wt[idx] = wt[7:0];
            end else begin
                pending.push_back(search(sr, sc, gr, gc));
            end
        endfunction

        // Called for every result the block presents.
        function void check_result(bit f, bit [39:0] cost);
            outcome_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result found=%0d cost=%0d", f, cost);
                return;
            end
            want = pending.pop_front();
            if (want.found !== f || want.cost !== cost) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: expected found=%0d cost=%0d, got found=%0d cost=%0d",
                             want.found, want.cost, f, cost);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        action = 1'b0;
    logic [11:0] cell_index = '0;
    logic [7:0]  cell_weight_in = '0;
    logic [5:0]  start_row = '0;
    logic [5:0]  start_col = '0;
    logic [5:0]  goal_row = '0;
    logic [5:0]  goal_col = '0;
    logic        done;
    logic        found;
    logic [39:0] path_cost;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    path_scoreboard cost_board = new();

    // Cells the stimulus has loaded so far; a search must never read any other cell.
    bit     loaded[NCELLS];
    int     idle_pct = 0;
    longint cycle_count = 0;

    grid_astar_path_search_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .action(action),
        .cell_index(cell_index), .cell_weight_in(cell_weight_in),
        .start_row(start_row), .start_col(start_col),
        .goal_row(goal_row), .goal_col(goal_col),
        .done(done), .found(found), .path_cost(path_cost),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Results cannot be stalled, so every cycle with done high is checked.
    always @(posedge clk) begin
        if (rst_n && done) cost_board.check_result(found, path_cost);
    end

    // Watchdog against a hung search.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Sends one request; inputs change on the falling edge, and the request
    // is taken at the first rising edge where busy is low.
    task automatic send(bit act, int idx, int wt, int sr, int sc, int gr, int gc);
        while ($urandom_range(99) < idle_pct) @(negedge clk);
        start = 1'b1;
        action = act;
        cell_index = idx[11:0];
        cell_weight_in = wt[7:0];
        start_row = sr[5:0];
        start_col = sc[5:0];
        goal_row = gr[5:0];
        goal_col = gc[5:0];
        do @(posedge clk); while (busy);
        if (act == ACT_LOAD && idx < cost_board.used_rows() * cost_board.used_cols())
            loaded[idx] = 1'b1;
        cost_board.note_request(act, idx, wt, sr, sc, gr, gc);
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic load_cell(int idx, int wt);
        send(ACT_LOAD, idx, wt, $urandom_range(63), $urandom_range(63),
             $urandom_range(63), $urandom_range(63));
    endtask

    task automatic run_search(int sr, int sc, int gr, int gc);
        send(ACT_RUN, $urandom_range(4095), $urandom_range(255), sr, sc, gr, gc);
    endtask

    // Waits until every expected result is back and the block is idle.
    task automatic drain();
        while (cost_board.pending.size() != 0 || busy) @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_reg(logic [2:0] idx, int unsigned v);
        drain();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = v[15:0];
        do @(posedge clk); while (!cfg_ready);
        cost_board.set_reg(idx, v);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic configure(int rows, int cols, int cs, int dg, int ob);
        write_reg(REG_ROWS, rows);
        write_reg(REG_COLS, cols);
        write_reg(REG_CELLSIZE, cs);
        write_reg(REG_DIAG, dg);
        write_reg(REG_OBST, ob);
    endtask

    // Loads every cell in use that has never been written.
    task automatic fill_unloaded(int wt_max);
        int span;
        span = cost_board.used_rows() * cost_board.used_cols();
        for (int i = 0; i < span; i++)
            if (!loaded[i]) load_cell(i, $urandom_range(wt_max));
    endtask

    // Weights lean toward passable values, with extremes and obstacles mixed in.
    function automatic int pick_weight();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return 0;
        if (sel == 1) return 255;
        if (sel < 5) return $urandom_range(1, 4);
        return $urandom_range(255);
    endfunction

    initial begin
        int rows, cols, span, ob, cs, sel;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Directed part on a 4 x 5 grid.
        configure(4, 5, 256, 1, 255);
        for (int i = 0; i < 20; i++) load_cell(i, (i == 7) ? 255 : ((i == 3) ? 0 : 1));
        run_search(0, 0, 3, 4);          // corner to corner around an obstacle
        run_search(2, 2, 2, 2);          // start equals goal
        run_search(1, 2, 0, 0);          // start on an obstacle cell
        run_search(63, 0, 0, 0);         // start outside the grid
        run_search(0, 0, 0, 63);         // goal outside the grid
        load_cell(4095, 255);            // load outside the grid is ignored
        // Wall off the goal corner, so the open list runs empty.
        load_cell(13, 255);
        load_cell(18, 255);
        load_cell(14, 255);
        run_search(0, 0, 3, 4);
        write_reg(REG_DIAG, 0);
        run_search(0, 0, 2, 4);          // Manhattan, four neighbors
        write_reg(REG_CELLSIZE, 65535);
        run_search(3, 0, 0, 4);          // largest cell size
        write_reg(REG_CELLSIZE, 0);
        run_search(3, 0, 0, 4);          // zero cell size
        write_reg(REG_OBST, 0);
        run_search(0, 0, 0, 1);          // everything blocked
        write_reg(REG_OBST, 256);
        run_search(0, 0, 3, 4);          // nothing blocked

        // Tall and wide grids at the row and column limits with light weights in unloaded cells;
        // register values above 64 saturate to 64.
        configure(100, 6, 256, 1, 256);
        fill_unloaded(1);
        run_search(0, 0, 63, 5);
        run_search(63, 0, 0, 5);
        configure(6, 127, 256, 1, 256);
        fill_unloaded(1);
        run_search(0, 0, 5, 63);
        run_search(5, 63, 0, 0);

        // Random phases with small grids and varying registers and idling.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 77;
                2: idle_pct = 0;
                default: idle_pct = 25;
            endcase
            rows = (ph == 5) ? 1 : $urandom_range(1, 8);
            cols = (ph == 6) ? 1 : $urandom_range(1, 8);
            sel = $urandom_range(5);
            cs = (sel == 0) ? 0 : (sel == 1) ? 65535 : $urandom_range(65535);
            sel = $urandom_range(5);
            ob = (sel == 0) ? 0 : (sel == 1) ? 256 : $urandom_range(2, 256);
            configure(rows, cols, cs, $urandom_range(1), ob);
            fill_unloaded(255);
            span = rows * cols;
            for (int k = 0; k < 100; k++) begin
                if (k == 50) drain();   // sender holds off until all results are back
                sel = $urandom_range(99);
                if (sel < 75) begin
                    load_cell($urandom_range(span - 1), pick_weight());
                end else if (sel < 80) begin
                    load_cell($urandom_range(4095), $urandom_range(255));
                end else if (sel < 96) begin
                    run_search($urandom_range(rows - 1), $urandom_range(cols - 1),
                               $urandom_range(rows - 1), $urandom_range(cols - 1));
                end else begin
                    run_search($urandom_range(63), $urandom_range(63),
                               $urandom_range(63), $urandom_range(63));
                end
            end
        end

        drain();
        repeat (50) @(posedge clk);
        if (cost_board.mismatches == 0 && cost_board.pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
